// ===== hw/rtl/time_weighted_sensor_aggregator_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the time-weighted sensor aggregator
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef TIME_WEIGHTED_SENSOR_AGGREGATOR_UNIT_ASSERT_SVH
`define TIME_WEIGHTED_SENSOR_AGGREGATOR_UNIT_ASSERT_SVH

// Check a consequent in the same cycle as the antecedent
`define TWSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after the antecedent
`define TWSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/twsa_pkg.sv =====
// ---------------------------------------------------------------------------
// twsa_pkg
// Shared types, widths and codes of the time-weighted sensor aggregator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package twsa_pkg;

  localparam int StampW   = 48;
  localparam int ValueW   = 32;
  localparam int SumW     = 64;
  localparam int ProdW    = ValueW + StampW;
  localparam int MulSteps = StampW;
  localparam int DivSteps = SumW;
  localparam int CntW     = $clog2(DivSteps);

  typedef logic [StampW-1:0]        stamp_t;
  typedef logic signed [ValueW-1:0] value_t;
  typedef logic signed [SumW-1:0]   sum_t;

  // Request codes of an input item
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_FOLD   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Aggregate selection
  typedef enum logic [2:0] {
    MODE_LAST = 3'd0,
    MODE_MIN  = 3'd1,
    MODE_MAX  = 3'd2,
    MODE_AVG  = 3'd3,
    MODE_SUM  = 3'd4
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/time_weighted_sensor_aggregator_unit.sv =====
// ---------------------------------------------------------------------------
// time_weighted_sensor_aggregator_unit
// Keeps running accumulators over timestamped Q16.16 readings and answers
// report items with the last reading, minimum, maximum, time-weighted
// average or time-weighted sum, as aggregate_mode selects. Each reading is
// weighted by the ticks until the next one; a report adds the open tail up
// to its own stamp, and a fold report restarts the window from the result.
// The block takes one item at a time. A reading after the first runs from
// acceptance until in_ready returns through a 48-step shift-add multiply,
// one multiplier bit a cycle, then a saturate and an accumulate step. Last,
// minimum and maximum reports use the held readings, a sum report runs the
// multiply, an average report adds a 64-step restoring division, one
// quotient bit a cycle, and an average fold multiplies again to weight the
// new average. Multiply and divide share one adder. The result sits in an
// output register, so the block goes on with the next item while it waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module time_weighted_sensor_aggregator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       aggregate_mode,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       req_type,
  input  twsa_pkg::stamp_t stamp,
  input  twsa_pkg::value_t sample_value,
  output logic             out_valid,
  input  logic             out_ready,
  output twsa_pkg::stamp_t result_stamp,
  output twsa_pkg::sum_t   result_value,
  output logic [1:0]       status
);

  import twsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUICK,
    S_MUL,
    S_FIN1,
    S_FIN2,
    S_DISP,
    S_DIV,
    S_DFIN
  } state_t;

  localparam logic [CntW-1:0] MulLast = CntW'(MulSteps - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);
  localparam sum_t SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam sum_t SumMin = {1'b1, {(SumW-1){1'b0}}};
  localparam sum_t ValMax = sum_t'({1'b0, {(ValueW-1){1'b1}}});
  localparam sum_t ValMin = -sum_t'({1'b1, {(ValueW-1){1'b0}}});
  localparam int   AluW   = StampW + 1;

  // Control
  state_t            state;
  logic [CntW-1:0]   cnt;
  logic              pass2;
  logic [2:0]        mode_cfg;
  logic              have_reading;

  // Latched item
  req_t              req_r;
  mode_t             mode_r;
  stamp_t            t_r;
  value_t            v_r;

  // Window state
  stamp_t            last_stamp, first_stamp, low_stamp, high_stamp;
  value_t            last_value, low_value, high_value;
  sum_t              weighted_sum;
  stamp_t            elapsed_sum;
  logic              sum_sat;

  // Shared datapath registers
  logic [ValueW-1:0] mag;
  logic              mneg;
  stamp_t            dur;
  logic [ProdW-1:0]  prod;
  sum_t              term;
  logic              msat;
  sum_t              wsr;
  stamp_t            elr;
  logic              satr;
  logic [SumW-1:0]   quo;
  stamp_t            rem;
  value_t            avg;

  // Combinational signals
  mode_t             mode_eff;
  req_t              req_in;
  logic              acc, out_free, is_report_in, slow_in, go_div;
  stamp_t            d_in, d0;
  logic [AluW-1:0]   alu_a, alu_b;
  logic              alu_cin;
  logic [AluW:0]     alu_sum;
  logic [ProdW-1:0]  prod_step;
  logic              qbit;
  stamp_t            rem_step;
  logic [SumW-1:0]   quo_step;
  logic [SumW-1:0]   bound, p_mag;
  logic              mul_over;
  sum_t              term_next;
  sum_t              ws_raw, ws_next;
  logic              ws_ovf;
  logic [StampW:0]   el_wide;
  stamp_t            el_next;
  sum_t              q_signed;
  value_t            avg_next;
  stamp_t            sel_stamp;
  value_t            sel_value;
  logic              emit;
  stamp_t            em_stamp;
  sum_t              em_value;
  status_t           em_status;
  logic              ld_single, ld_pair, ld_read;
  stamp_t            sg_stamp, pr_t0, pr_el;
  value_t            sg_value, pr_v0;
  sum_t              pr_c;
  logic              pr_sat;

  function automatic stamp_t span(stamp_t to_t, stamp_t from_t);
    return (to_t >= from_t) ? stamp_t'(to_t - from_t) : '0;
  endfunction

  function automatic value_t clamp32(sum_t x);
    value_t r;
    if (x > ValMax) begin
      r = value_t'(ValMax);
    end else if (x < ValMin) begin
      r = value_t'(ValMin);
    end else begin
      r = x[ValueW-1:0];
    end
    return r;
  endfunction

  function automatic logic [ValueW-1:0] mag_of(value_t v);
    return v[ValueW-1] ? ValueW'(-v) : ValueW'(v);
  endfunction

  // Decode the incoming item
  assign cfg_ready    = 1'b1;
  assign in_ready     = (state == S_IDLE);
  assign acc          = in_valid && in_ready;
  assign req_in       = req_t'(req_type);
  assign out_free     = !out_valid || out_ready;
  assign mode_eff     = (mode_cfg > 3'(MODE_SUM)) ? MODE_LAST : mode_t'(mode_cfg);
  assign is_report_in = (req_in == REQ_REPORT) || (req_in == REQ_FOLD);
  assign slow_in      = have_reading && ((req_in == REQ_ADD) ||
                        (is_report_in && (mode_eff == MODE_AVG || mode_eff == MODE_SUM)));
  assign d_in         = span(stamp, last_stamp);
  assign d0           = span(t_r, first_stamp);
  assign go_div       = (state == S_DISP) && (mode_r == MODE_AVG) && (elr != '0);

  // Shared adder: multiply step adds the multiplicand, divide step subtracts
  always_comb begin
    if (state == S_DIV) begin
      alu_a   = {rem, quo[SumW-1]};
      alu_b   = ~{1'b0, elr};
      alu_cin = 1'b1;
    end else begin
      alu_a   = AluW'(prod[ProdW-1:StampW]);
      alu_b   = prod[0] ? AluW'(mag) : '0;
      alu_cin = 1'b0;
    end
    alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (AluW+1)'(alu_cin);
  end

  assign prod_step = {alu_sum[ValueW:0], prod[StampW-1:1]};
  assign qbit      = alu_sum[AluW];
  assign rem_step  = qbit ? alu_sum[StampW-1:0] : alu_a[StampW-1:0];
  assign quo_step  = {quo[SumW-2:0], qbit};

  // Saturate the product to the signed 64-bit range
  assign bound     = mneg ? SumMin : SumMax;
  assign mul_over  = prod > {{(ProdW-SumW){1'b0}}, bound};
  assign p_mag     = mul_over ? bound : prod[SumW-1:0];
  assign term_next = mneg ? -sum_t'(p_mag) : sum_t'(p_mag);

  // Accumulate with saturation
  assign ws_raw  = weighted_sum + term;
  assign ws_ovf  = (weighted_sum[SumW-1] == term[SumW-1]) &&
                   (ws_raw[SumW-1] != weighted_sum[SumW-1]);
  assign ws_next = ws_ovf ? (weighted_sum[SumW-1] ? SumMin : SumMax) : ws_raw;
  assign el_wide = {1'b0, elapsed_sum} + {1'b0, dur};
  assign el_next = el_wide[StampW] ? '1 : el_wide[StampW-1:0];

  // Sign the quotient
  assign q_signed = wsr[SumW-1] ? -sum_t'(quo) : sum_t'(quo);
  assign avg_next = clamp32(q_signed);

  // Pick the reading for last, minimum and maximum
  always_comb begin
    unique case (mode_r)
      MODE_MIN: begin
        sel_stamp = low_stamp;
        sel_value = low_value;
      end
      MODE_MAX: begin
        sel_stamp = high_stamp;
        sel_value = high_value;
      end
      default: begin
        sel_stamp = last_stamp;
        sel_value = last_value;
      end
    endcase
  end

  // Form the result item
  always_comb begin
    emit      = 1'b0;
    em_stamp  = t_r;
    em_value  = '0;
    em_status = ST_OK;
    unique case (state)
      S_QUICK: begin
        emit = out_free;
        if (have_reading) begin
          em_stamp = sel_stamp;
          em_value = sum_t'(sel_value);
        end else begin
          em_status = ST_EMPTY;
        end
      end
      S_DISP: begin
        emit = out_free && !go_div;
        if (mode_r == MODE_SUM) begin
          em_value  = wsr;
          em_status = satr ? ST_SAT : ST_OK;
        end else begin
          em_status = ST_ZERO;
        end
      end
      S_DFIN: begin
        emit      = out_free;
        em_value  = q_signed;
        em_status = satr ? ST_SAT : ST_OK;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Choose how the window state reloads
  always_comb begin
    ld_single = 1'b0;
    ld_pair   = 1'b0;
    ld_read   = 1'b0;
    sg_stamp  = stamp;
    sg_value  = sample_value;
    pr_t0     = first_stamp;
    pr_v0     = avg;
    pr_c      = term;
    pr_el     = dur;
    pr_sat    = msat;
    if (acc && req_in == REQ_ADD && !have_reading) begin
      ld_single = 1'b1;
    end else if (state == S_QUICK && out_free && have_reading && req_r == REQ_FOLD) begin
      ld_single = 1'b1;
      sg_stamp  = sel_stamp;
      sg_value  = sel_value;
    end else if (state == S_FIN2 && pass2) begin
      ld_pair = 1'b1;
    end else if (state == S_FIN2 && req_r == REQ_ADD) begin
      ld_read = 1'b1;
    end else if (state == S_DISP && mode_r == MODE_SUM && out_free &&
                 req_r == REQ_FOLD && t_r != '0) begin
      ld_pair = 1'b1;
      pr_t0   = t_r - stamp_t'(1);
      pr_v0   = clamp32(wsr);
      pr_c    = wsr;
      pr_el   = stamp_t'(1);
      pr_sat  = satr;
    end
  end

  // Sequence the item and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      pass2        <= 1'b0;
      mode_cfg     <= 3'(MODE_LAST);
      have_reading <= 1'b0;
      out_valid    <= 1'b0;
      result_stamp <= '0;
      result_value <= '0;
      status       <= 2'(ST_OK);
    end else begin
      if (cfg_valid) begin
        mode_cfg <= aggregate_mode;
      end
      if (emit) begin
        out_valid    <= 1'b1;
        result_stamp <= em_stamp;
        result_value <= em_value;
        status       <= 2'(em_status);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (req_in == REQ_ADD && !have_reading) begin
              have_reading <= 1'b1;
            end else if (slow_in) begin
              cnt   <= '0;
              pass2 <= 1'b0;
              state <= S_MUL;
            end else if (is_report_in) begin
              state <= S_QUICK;
            end
          end
        end
        S_QUICK: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          cnt <= cnt + CntW'(1);
          if (cnt == MulLast) begin
            state <= S_FIN1;
          end
        end
        S_FIN1: begin
          state <= S_FIN2;
        end
        S_FIN2: begin
          state <= (pass2 || req_r == REQ_ADD) ? S_IDLE : S_DISP;
        end
        S_DISP: begin
          if (go_div) begin
            cnt   <= '0;
            state <= S_DIV;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          cnt <= cnt + CntW'(1);
          if (cnt == DivLast) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          if (out_free) begin
            if (req_r == REQ_FOLD) begin
              cnt   <= '0;
              pass2 <= 1'b1;
              state <= S_MUL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath and window state
  always_ff @(posedge clk) begin
    // Capture the item
    if (acc) begin
      req_r  <= req_in;
      mode_r <= mode_eff;
      t_r    <= stamp;
      v_r    <= sample_value;
    end
    // Load the multiplier with the last value and its held duration
    if (acc && slow_in) begin
      mag  <= mag_of(last_value);
      mneg <= last_value[ValueW-1];
      prod <= {{ValueW{1'b0}}, d_in};
      dur  <= d_in;
    end
    // Advance the shift-add multiply
    if (state == S_MUL) begin
      prod <= prod_step;
    end
    if (state == S_FIN1) begin
      term <= term_next;
      msat <= mul_over;
    end
    // Hold the report totals
    if (state == S_FIN2 && !pass2) begin
      wsr  <= ws_next;
      elr  <= el_next;
      satr <= sum_sat || msat || ws_ovf;
    end
    // Load the divider with the sum magnitude
    if (go_div) begin
      quo <= wsr[SumW-1] ? SumW'(-wsr) : SumW'(wsr);
      rem <= '0;
    end
    // Advance the restoring divide
    if (state == S_DIV) begin
      quo <= quo_step;
      rem <= rem_step;
    end
    // Weight the new average over the window for a fold
    if (state == S_DFIN && out_free && req_r == REQ_FOLD) begin
      avg  <= avg_next;
      mag  <= mag_of(avg_next);
      mneg <= avg_next[ValueW-1];
      prod <= {{ValueW{1'b0}}, d0};
      dur  <= d0;
    end
    // Reload or advance the window
    if (ld_single) begin
      first_stamp  <= sg_stamp;
      last_stamp   <= sg_stamp;
      last_value   <= sg_value;
      low_stamp    <= sg_stamp;
      low_value    <= sg_value;
      high_stamp   <= sg_stamp;
      high_value   <= sg_value;
      weighted_sum <= '0;
      elapsed_sum  <= '0;
      sum_sat      <= 1'b0;
    end else if (ld_pair) begin
      first_stamp  <= pr_t0;
      last_stamp   <= t_r;
      weighted_sum <= pr_c;
      elapsed_sum  <= pr_el;
      sum_sat      <= pr_sat;
      if (pr_v0 <= last_value) begin
        low_value <= pr_v0;
        low_stamp <= pr_t0;
      end else begin
        low_stamp <= t_r;
      end
      if (pr_v0 >= last_value) begin
        high_value <= pr_v0;
        high_stamp <= pr_t0;
      end else begin
        high_stamp <= t_r;
      end
      if (pr_v0 > last_value) begin
        low_value <= last_value;
      end
      if (pr_v0 < last_value) begin
        high_value <= last_value;
      end
    end else if (ld_read) begin
      weighted_sum <= ws_next;
      sum_sat      <= sum_sat || msat || ws_ovf;
      elapsed_sum  <= el_next;
      last_stamp   <= t_r;
      last_value   <= v_r;
      if (v_r < low_value) begin
        low_value <= v_r;
        low_stamp <= t_r;
      end
      if (v_r > high_value) begin
        high_value <= v_r;
        high_stamp <= t_r;
      end
    end
  end

endmodule

// ===== hw/rtl/twsa_checker.sv =====
// ---------------------------------------------------------------------------
// twsa_checker
// Port-level checks of the time-weighted sensor aggregator, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "time_weighted_sensor_aggregator_unit_assert.svh"

module twsa_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [1:0]       req_type,
  input logic             out_valid,
  input logic             out_ready,
  input twsa_pkg::stamp_t result_stamp,
  input twsa_pkg::sum_t   result_value,
  input logic [1:0]       status
);

  import twsa_pkg::*;

  // Hold a stalled result item
  `TWSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(result_stamp) && $stable(status), "stalled result item changed")

  // Drop no result right after a reading
  `TWSA_ASSERT_NEXT(a_add_no_result, in_valid && in_ready && req_type == REQ_ADD, !$rose(out_valid), "reading item produced a result")

  // Go busy after taking a report
  `TWSA_ASSERT_NEXT(a_busy_after_report, in_valid && in_ready && (req_type == REQ_REPORT || req_type == REQ_FOLD), !in_ready, "ready stayed high after a report item")

  // Zero the value of flagged results
  `TWSA_ASSERT_IMPL(a_flag_zero_value, out_valid && (status == ST_EMPTY || status == ST_ZERO), result_value == '0, "flagged result carries a value")

endmodule

bind time_weighted_sensor_aggregator_unit twsa_checker u_twsa_checker (.*);
